>>> hdl/sfc_pkg.sv
// Shared constants, item types and helper structs for the sphere frustum culler.
package sfc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int PLANE_COUNT = 6;

  localparam int WORD_W  = 32;
  localparam int ROW_W   = 4 * WORD_W;
  localparam int MADDR_W = 2;
  localparam int PADDR_W = $clog2(PLANE_COUNT);

  localparam int MAG_W   = WORD_W + 1;
  localparam int SHC_W   = 5;
  localparam int SH_MAX  = FRAC_BITS + 29;
  localparam int SH_W    = $clog2(SH_MAX + 1);
  localparam int DCNT_W  = $clog2(SH_MAX + MAG_W + 1);
  localparam int QW      = WORD_W - 1;
  localparam int MUL_W   = WORD_W + 1;
  localparam int ACC_W   = 2 * MUL_W;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int SQ_STEPS = SUM_W / 2;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         row_index;
    logic signed [31:0] word_0;
    logic signed [31:0] word_1;
    logic signed [31:0] word_2;
    logic signed [31:0] word_3;
    logic               has_bounds;
  } item_t;

  typedef struct packed {
    logic visible;
    logic status;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  num;
    logic [ROOT_W-1:0] den;
    logic [SH_W-1:0]   sh;
  } div_req_t;

endpackage

>>> hdl/sfc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/sfc_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module sfc_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sfc_pkg::SUM_W-1:0] radicand,
  output logic                      done,
  output logic [sfc_pkg::ROOT_W-1:0] root
);

  logic [sfc_pkg::SUM_W-1:0] x;
  logic [sfc_pkg::SUM_W-1:0] res;
  logic [sfc_pkg::SUM_W-1:0] bitv;
  logic [sfc_pkg::SUM_W-1:0] trial;
  logic [$clog2(sfc_pkg::SQ_STEPS+1)-1:0] cnt;
  logic busy;

  assign trial = res + bitv;
  assign root  = res[sfc_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= radicand;
        res  <= '0;
        bitv <= sfc_pkg::SUM_W'(1) << (sfc_pkg::SUM_W - 2);
        cnt  <= ($clog2(sfc_pkg::SQ_STEPS+1))'(sfc_pkg::SQ_STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        if (x >= trial) begin
          x   <= x - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 1'b1;
        if (cnt == ($clog2(sfc_pkg::SQ_STEPS+1))'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/sfc_div.sv
// Bit-serial restoring divider computing a saturated trunc(num * 2^sh / den).
module sfc_div (
  input  logic                  clk,
  input  logic                  rst,
  input  sfc_pkg::div_req_t     req,
  output logic                  done,
  output logic [sfc_pkg::QW-1:0] quot
);

  logic [sfc_pkg::MAG_W-1:0]  nsh;
  logic [sfc_pkg::ROOT_W-1:0] den;
  logic [sfc_pkg::ROOT_W-1:0] rem;
  logic [sfc_pkg::ROOT_W:0]   t;
  logic [sfc_pkg::QW-1:0]     q;
  logic [sfc_pkg::DCNT_W-1:0] cnt;
  logic                       ovf;
  logic                       busy;
  logic                       qbit;

  assign t    = {rem, nsh[sfc_pkg::MAG_W-1]};
  assign qbit = (t >= {1'b0, den});
  assign quot = ovf ? {sfc_pkg::QW{1'b1}} : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        nsh  <= req.num;
        den  <= req.den;
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
        cnt  <= sfc_pkg::DCNT_W'(sfc_pkg::MAG_W) + sfc_pkg::DCNT_W'(req.sh);
        busy <= 1'b1;
      end else if (busy) begin
        if (qbit) begin
          rem <= sfc_pkg::ROOT_W'(t - {1'b0, den});
        end else begin
          rem <= t[sfc_pkg::ROOT_W-1:0];
        end
        q   <= {q[sfc_pkg::QW-2:0], qbit};
        ovf <= ovf | q[sfc_pkg::QW-1];
        nsh <= nsh << 1;
        cnt <= cnt - 1'b1;
        if (cnt == sfc_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/sphere_frustum_culler_top.sv
// Top level: matrix and plane stores, plane build sequencer and sphere test.
// A sphere test walks the planes in turn and stops at the first plane that
// rejects the sphere, using the shared multiplier that forms one product of
// the dot product per cycle behind the plane store read. A build runs the
// six planes one after another; each plane goes through a normalizing shift,
// the squares, the square root unit and four serial divisions, and a plane
// whose normal is zero skips these steps. One item is worked at a time; a
// finished result waits in the output register while the next item is taken.
module sphere_frustum_culler_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sfc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sfc_pkg::result_t result
);

  typedef enum logic [18:0] {
    ST_IDLE   = 19'd1,
    ST_LOAD   = 19'd2,
    ST_B_RD3  = 19'd4,
    ST_B_RDK  = 19'd8,
    ST_B_SUM  = 19'd16,
    ST_B_NORM = 19'd32,
    ST_B_SQ   = 19'd64,
    ST_B_SQRT = 19'd128,
    ST_B_DIVS = 19'd256,
    ST_B_DIVW = 19'd512,
    ST_B_WR   = 19'd1024,
    ST_B_NEXT = 19'd2048,
    ST_T_RD   = 19'd4096,
    ST_T_M0   = 19'd8192,
    ST_T_M1   = 19'd16384,
    ST_T_M2   = 19'd32768,
    ST_T_M3   = 19'd65536,
    ST_T_CMP  = 19'd131072,
    ST_DONE   = 19'd262144
  } state_t;

  state_t state;
  sfc_pkg::item_t cur;

  logic [sfc_pkg::PADDR_W-1:0] p;
  logic [3:0][31:0] r3;
  logic [3:0] neg;
  logic [3:0][sfc_pkg::MAG_W-1:0] mag;
  logic [sfc_pkg::MAG_W-1:0] m;
  logic [sfc_pkg::SHC_W-1:0] up;
  logic [sfc_pkg::SHC_W-1:0] down;
  logic [1:0] sq_j;
  logic [sfc_pkg::SUM_W-1:0] sum;
  logic signed [sfc_pkg::ACC_W-1:0] prod;
  logic signed [sfc_pkg::ACC_W-1:0] acc;
  logic [sfc_pkg::ROOT_W-1:0] len;
  logic [1:0] di;
  logic [3:0][sfc_pkg::QW-1:0] mq;
  logic [3:0][31:0] pl;
  logic built;
  logic vis;
  logic [3:0] mvalid;
  logic [sfc_pkg::PLANE_COUNT-1:0] pvalid;
  logic mok;
  logic pok;

  logic                          mwe;
  logic [sfc_pkg::MADDR_W-1:0]   mraddr;
  logic [sfc_pkg::ROW_W-1:0]     mrdata;
  logic [3:0][31:0]              mrow;
  logic                          pwe;
  logic [sfc_pkg::ROW_W-1:0]     pwdata;
  logic [sfc_pkg::ROW_W-1:0]     prdata;
  logic [3:0][31:0]              prow;

  logic [3:0][sfc_pkg::MAG_W-1:0] vsum;
  logic [3:0][sfc_pkg::MAG_W-1:0] vmag;
  logic [sfc_pkg::MAG_W-1:0] vmax01;
  logic [sfc_pkg::MAG_W-1:0] vmax;
  logic signed [sfc_pkg::MUL_W-1:0] mul_a;
  logic signed [sfc_pkg::MUL_W-1:0] mul_b;
  logic signed [sfc_pkg::ACC_W-1:0] limit;
  logic [3:0][31:0] plane_out;

  logic sq_start;
  logic sq_done;
  logic [sfc_pkg::ROOT_W-1:0] sq_root;
  sfc_pkg::div_req_t div_req;
  logic div_done;
  logic [sfc_pkg::QW-1:0] div_q;

  logic take;

  assign item_stall = (state != ST_IDLE);
  assign take       = item_valid && !item_stall;

  sfc_ram #(.WIDTH(sfc_pkg::ROW_W), .DEPTH(4)) u_matrix (
    .clk   (clk),
    .we    (mwe),
    .waddr (cur.row_index),
    .wdata ({cur.word_3, cur.word_2, cur.word_1, cur.word_0}),
    .raddr (mraddr),
    .rdata (mrdata)
  );

  sfc_ram #(.WIDTH(sfc_pkg::ROW_W), .DEPTH(sfc_pkg::PLANE_COUNT)) u_planes (
    .clk   (clk),
    .we    (pwe),
    .waddr (p),
    .wdata (pwdata),
    .raddr (p),
    .rdata (prdata)
  );

  sfc_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sum + prod[sfc_pkg::SUM_W-1:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  sfc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_q)
  );

  assign mwe    = (state == ST_LOAD);
  assign mraddr = (state == ST_B_RD3) ? sfc_pkg::MADDR_W'(3) : sfc_pkg::MADDR_W'(p >> 1);
  assign mrow   = mok ? mrdata : '0;
  assign prow   = pok ? prdata : '0;
  assign sq_start = (state == ST_B_SQ) && (sq_j == 2'd3);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (p[0]) begin
        vsum[i] = {r3[i][31], r3[i]} - {mrow[i][31], mrow[i]};
      end else begin
        vsum[i] = {r3[i][31], r3[i]} + {mrow[i][31], mrow[i]};
      end
      vmag[i] = vsum[i][sfc_pkg::MAG_W-1] ? (~vsum[i] + 1'b1) : vsum[i];
    end
    vmax01 = (vmag[1] > vmag[0]) ? vmag[1] : vmag[0];
    vmax   = (vmag[2] > vmax01) ? vmag[2] : vmax01;
  end

  always_comb begin
    div_req.start = (state == ST_B_DIVS);
    div_req.den   = len;
    if (di == 2'd3) begin
      div_req.num = mag[3];
      div_req.sh  = sfc_pkg::SH_W'(sfc_pkg::FRAC_BITS) + sfc_pkg::SH_W'(up)
                    - sfc_pkg::SH_W'(down);
    end else begin
      div_req.num = mag[di];
      div_req.sh  = sfc_pkg::SH_W'(sfc_pkg::FRAC_BITS);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      plane_out[i] = neg[i] ? (32'd0 - {1'b0, mq[i]}) : {1'b0, mq[i]};
    end
    pwe    = (state == ST_B_WR) || ((state == ST_B_SUM) && (vmax == '0));
    pwdata = (state == ST_B_WR) ? plane_out : '0;
  end

  always_comb begin
    case (state)
      ST_B_SQ: begin
        mul_a = $signed(mag[sq_j]);
        mul_b = $signed(mag[sq_j]);
      end
      ST_T_M0: begin
        mul_a = $signed({prow[0][31], prow[0]});
        mul_b = $signed({cur.word_0[31], cur.word_0});
      end
      ST_T_M1: begin
        mul_a = $signed({pl[1][31], pl[1]});
        mul_b = $signed({cur.word_1[31], cur.word_1});
      end
      ST_T_M2: begin
        mul_a = $signed({pl[2][31], pl[2]});
        mul_b = $signed({cur.word_2[31], cur.word_2});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign limit = -($signed({{(sfc_pkg::ACC_W-32){cur.word_3[31]}}, cur.word_3})
                   <<< sfc_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    mok  <= mvalid[mraddr];
    pok  <= pvalid[p];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      built        <= 1'b0;
      mvalid       <= '0;
      pvalid       <= '0;
      p            <= '0;
      up           <= '0;
      down         <= '0;
    end else begin
      if (result_valid && !result_stall && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            cur <= item;
            p   <= '0;
            vis <= (item.command == sfc_pkg::CMD_TEST);
            case (item.command)
              sfc_pkg::CMD_LOAD:  state <= ST_LOAD;
              sfc_pkg::CMD_BUILD: state <= ST_B_RD3;
              sfc_pkg::CMD_TEST:  state <= item.has_bounds ? ST_T_RD : ST_DONE;
              default:            state <= ST_DONE;
            endcase
          end
        end
        ST_LOAD: begin
          mvalid[cur.row_index] <= 1'b1;
          state <= ST_DONE;
        end
        ST_B_RD3: begin
          state <= ST_B_RDK;
        end
        ST_B_RDK: begin
          if (p == '0) begin
            r3 <= mrow;
          end
          state <= ST_B_SUM;
        end
        ST_B_SUM: begin
          for (int i = 0; i < 4; i++) begin
            neg[i] <= vsum[i][sfc_pkg::MAG_W-1];
            mag[i] <= vmag[i];
          end
          m    <= vmax;
          up   <= '0;
          down <= '0;
          sq_j <= '0;
          state <= (vmax == '0) ? ST_B_NEXT : ST_B_NORM;
        end
        ST_B_NORM: begin
          if (|m[sfc_pkg::MAG_W-1:30]) begin
            m    <= m >> 1;
            down <= down + 1'b1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (m[sfc_pkg::MAG_W-1:29] == '0) begin
            m  <= m << 1;
            up <= up + 1'b1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            state <= ST_B_SQ;
          end
        end
        ST_B_SQ: begin
          if (sq_j == 2'd0) begin
            sum <= '0;
          end else begin
            sum <= sum + prod[sfc_pkg::SUM_W-1:0];
          end
          sq_j <= sq_j + 1'b1;
          if (sq_j == 2'd3) begin
            state <= ST_B_SQRT;
          end
        end
        ST_B_SQRT: begin
          if (sq_done) begin
            len   <= sq_root;
            di    <= '0;
            state <= ST_B_DIVS;
          end
        end
        ST_B_DIVS: begin
          state <= ST_B_DIVW;
        end
        ST_B_DIVW: begin
          if (div_done) begin
            mq[di] <= div_q;
            di     <= di + 1'b1;
            state  <= (di == 2'd3) ? ST_B_WR : ST_B_DIVS;
          end
        end
        ST_B_WR: begin
          pvalid[p] <= 1'b1;
          state <= ST_B_NEXT;
        end
        ST_B_NEXT: begin
          if (p == sfc_pkg::PADDR_W'(sfc_pkg::PLANE_COUNT - 1)) begin
            built <= 1'b1;
            state <= ST_DONE;
          end else begin
            p     <= p + 1'b1;
            state <= ST_B_RDK;
          end
        end
        ST_T_RD: begin
          state <= ST_T_M0;
        end
        ST_T_M0: begin
          pl  <= prow;
          acc <= $signed({{(sfc_pkg::ACC_W-32){prow[3][31]}}, prow[3]})
                 <<< sfc_pkg::FRAC_BITS;
          state <= ST_T_M1;
        end
        ST_T_M1: begin
          acc <= acc + prod;
          state <= ST_T_M2;
        end
        ST_T_M2: begin
          acc <= acc + prod;
          state <= ST_T_M3;
        end
        ST_T_M3: begin
          acc <= acc + prod;
          state <= ST_T_CMP;
        end
        ST_T_CMP: begin
          if (acc < limit) begin
            vis   <= 1'b0;
            state <= ST_DONE;
          end else if (p == sfc_pkg::PADDR_W'(sfc_pkg::PLANE_COUNT - 1)) begin
            state <= ST_DONE;
          end else begin
            p     <= p + 1'b1;
            state <= ST_T_RD;
          end
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid   <= 1'b1;
            result.visible <= vis;
            result.status  <= (cur.command == sfc_pkg::CMD_TEST) && !built;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_plane_index: assert property (@(posedge clk) disable iff (rst)
    p <= sfc_pkg::PADDR_W'(sfc_pkg::PLANE_COUNT - 1))
    else $error("plane index out of range");

  a_one_shift_dir: assert property (@(posedge clk) disable iff (rst)
    !((up != '0) && (down != '0)))
    else $error("normalize shifted both ways");

  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_B_SQRT) && sq_done |-> sq_root != '0)
    else $error("zero normal length reached divider");

  a_unit_normal: assert property (@(posedge clk) disable iff (rst)
    state == ST_B_WR |-> (mq[0] <= sfc_pkg::QW'(1 << sfc_pkg::FRAC_BITS))
                      && (mq[1] <= sfc_pkg::QW'(1 << sfc_pkg::FRAC_BITS))
                      && (mq[2] <= sfc_pkg::QW'(1 << sfc_pkg::FRAC_BITS)))
    else $error("normal component above one");

endmodule
